/* hdl/slot_path_reference_checker_assert.svh */
// Assertion macros used by the checker file of the slot path reference checker.
`ifndef SLOT_PATH_REFERENCE_CHECKER_ASSERT_SVH
`define SLOT_PATH_REFERENCE_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/spr_pkg.sv */
package spr_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
  } char_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] slot;
    logic [7:0] path_length;
  } result_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Header positions: 0 to 3 walk through the word "boot".
  localparam logic [2:0] POS_SLOT  = 3'd4;
  localparam logic [2:0] POS_COLON = 3'd5;
  localparam logic [2:0] POS_SLASH = 3'd6;
  localparam logic [2:0] POS_PATH  = 3'd7;

  localparam logic [7:0] CHAR_PRINT_LOW  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HIGH = 8'h7e;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_THREE      = 8'h33;
  localparam logic [7:0] CHAR_COLON      = 8'h3a;
  localparam logic [7:0] CHAR_DOT        = 8'h2e;
  localparam logic [7:0] CHAR_SLASH      = 8'h2f;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5c;

  localparam logic [1:0] COMP_LEN_SAT = 2'd3;

  function automatic logic [7:0] header_letter(input logic [1:0] idx);
    logic [7:0] letter;
    unique case (idx)
      2'd0:    letter = 8'h62;
      2'd1:    letter = 8'h6f;
      2'd2:    letter = 8'h6f;
      default: letter = 8'h74;
    endcase
    return letter;
  endfunction

endpackage

/* hdl/slot_path_reference_checker.sv */
// Checks slot path references of the form boot<0-3>:[/]path, one character per beat.
// The block takes one character every cycle while in_stall is low. A character is held in
// an input register and scanned there combinationally; the result of a string's last
// character enters a two-entry output queue and is offered from there once written.
// Input stalls only when the input register holds a last character and both queue
// entries still wait on the output side.
module slot_path_reference_checker
  import spr_pkg::*;
#(
  parameter int PATH_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  char_beat_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_data
);

  logic       r_valid;
  char_beat_t r_beat;
  logic       take;
  logic       room;
  result_t    result;

  // Only a last character produces a result and needs a free queue entry.
  assign take     = r_valid && (!r_beat.final_char || room);
  assign in_stall = r_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      r_valid <= 1'b1;
    end else if (take) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) r_beat <= in_data;
  end

  spr_scan #(
    .PATH_CAPACITY(PATH_CAPACITY)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .beat   (r_beat),
    .result (result)
  );

  spr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take && r_beat.final_char),
    .item      (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/spr_scan.sv */
module spr_scan
  import spr_pkg::*;
#(
  parameter int PATH_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  char_beat_t beat,
  output result_t    result
);

  localparam int CW = $clog2(PATH_CAPACITY + 1);

  logic [2:0]    pos, pos_next;
  logic [1:0]    err, err_next;
  logic [1:0]    slot, slot_next;
  logic [CW-1:0] count, count_next, count_inc;
  logic [1:0]    comp_len, comp_len_next;
  logic          all_dots, all_dots_next;
  logic          do_path, stepped, comp_bad, end_bad, char_bad;
  logic [7:0]    c;
  logic [1:0]    st;
  logic [CW+7:0] count_wide;

  always_comb begin
    c             = beat.character;
    pos_next      = pos;
    err_next      = err;
    slot_next     = slot;
    count_next    = count;
    comp_len_next = comp_len;
    all_dots_next = all_dots;
    do_path       = 1'b0;
    stepped       = 1'b0;
    count_inc     = count + 1'b1;
    comp_bad      = (comp_len == 2'd0) || (comp_len != COMP_LEN_SAT && all_dots);
    char_bad      = (c < CHAR_PRINT_LOW) || (c > CHAR_PRINT_HIGH) || (c == CHAR_BACKSLASH);

    if (err == ST_OK) begin
      priority if (pos < POS_SLOT) begin
        if (c != header_letter(pos[1:0])) err_next = ST_INVALID;
        else pos_next = pos + 3'd1;
      end else if (pos == POS_SLOT) begin
        if (c < CHAR_ZERO || c > CHAR_THREE) begin
          err_next = ST_INVALID;
        end else begin
          slot_next = c[1:0];
          pos_next  = POS_COLON;
        end
      end else if (pos == POS_COLON) begin
        if (c != CHAR_COLON) err_next = ST_INVALID;
        else pos_next = POS_SLASH;
      end else if (pos == POS_SLASH) begin
        pos_next = POS_PATH;
        do_path  = (c != CHAR_SLASH);
      end else begin
        do_path = 1'b1;
      end
    end

    if (do_path) begin
      if (c == CHAR_SLASH) begin
        if (comp_bad) begin
          err_next = ST_INVALID;
        end else begin
          comp_len_next = 2'd0;
          all_dots_next = 1'b1;
          stepped       = 1'b1;
        end
      end else if (char_bad) begin
        err_next = ST_INVALID;
      end else begin
        if (comp_len != COMP_LEN_SAT) comp_len_next = comp_len + 2'd1;
        all_dots_next = all_dots && (c == CHAR_DOT);
        stepped       = 1'b1;
      end
    end

    // The count never passes the capacity, since reaching it latches an error.
    if (stepped) begin
      count_next = count_inc;
      if (count_inc == CW'(PATH_CAPACITY)) err_next = ST_TOO_LONG;
    end

    end_bad = (comp_len_next == 2'd0) ||
              (comp_len_next != COMP_LEN_SAT && all_dots_next);
    st = err_next;
    if (st == ST_OK && (pos_next != POS_PATH || end_bad)) st = ST_INVALID;

    count_wide         = {8'd0, count_next};
    result.status      = st;
    result.slot        = (st == ST_OK) ? slot_next : 2'd0;
    result.path_length = (st == ST_OK) ? count_wide[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && beat.final_char)) begin
      pos      <= 3'd0;
      err      <= ST_OK;
      slot     <= 2'd0;
      count    <= '0;
      comp_len <= 2'd0;
      all_dots <= 1'b1;
    end else if (take) begin
      pos      <= pos_next;
      err      <= err_next;
      slot     <= slot_next;
      count    <= count_next;
      comp_len <= comp_len_next;
      all_dots <= all_dots_next;
    end
  end

endmodule

/* hdl/spr_out_queue.sv */
module spr_out_queue
  import spr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t item,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t    mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign room      = (count != 2'd2);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/spr_checker.sv */
`include "slot_path_reference_checker_assert.svh"

module spr_checker
  import spr_pkg::*;
#(
  parameter int PATH_CAPACITY = 256
) (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  `SPR_ASSERT_NOW(a_status_code, out_valid, out_data.status != 2'd3, "status code out of range")
  `SPR_ASSERT_NOW(a_error_zeroes, out_valid && out_data.status != ST_OK, out_data.slot == 2'd0 && out_data.path_length == 8'd0, "error result carries slot or length")
  `SPR_ASSERT_NOW(a_length_bound, out_valid && out_data.status == ST_OK, PATH_CAPACITY > 256 || int'(out_data.path_length) < PATH_CAPACITY, "accepted path reaches capacity")
  `SPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind slot_path_reference_checker spr_checker #(
  .PATH_CAPACITY(PATH_CAPACITY)
) u_spr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
